// ----- design/pfa_pkg.sv -----
package pfa_pkg;

    localparam int FRAME_COUNT_DEF   = 16;
    localparam int SEGMENT_SLOTS_DEF = 8;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_REF    = 2'd1;
    localparam logic [1:0] OP_UNLOAD = 2'd2;

    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_EVICT = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] seg_id;
        logic [7:0] owner_process;
        logic [4:0] page_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [3:0] frame_index;
        logic [7:0] event_segment;
        logic       last_of_run;
    } t_out_item;

endpackage

// ----- design/page_frame_allocator_second_chance.sv -----
// Page frame table with second-chance segment eviction. One request is taken
// at a time and o_in_ready is high only while the sequencer is idle. Every
// step goes through one compare unit and one frame or slot per cycle while
// the output is not stalled: a reference scans the segment slots, an unload
// scans the slots and then releases the segment's frames, and a load scans
// the slots, checks free frames and slots, evicts segments with the clock
// hand and releases their frames while short of either, then allocates frames.
// Results leave through a one-entry output register, one item per cycle at
// most.
module page_frame_allocator_second_chance #(
    parameter int FRAME_COUNT   = pfa_pkg::FRAME_COUNT_DEF,
    parameter int SEGMENT_SLOTS = pfa_pkg::SEGMENT_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pfa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pfa_pkg::t_out_item o_out_item
);
    import pfa_pkg::*;

    localparam int FW  = $clog2(FRAME_COUNT);
    localparam int FCW = $clog2(FRAME_COUNT + 1);
    localparam int SW  = $clog2(SEGMENT_SLOTS);
    localparam int SCW = $clog2(SEGMENT_SLOTS + 1);
    localparam int GW  = $clog2(2 * SEGMENT_SLOTS + 2);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIND   = 3'd1;
    localparam logic [2:0] ST_FREL   = 3'd2;
    localparam logic [2:0] ST_CHECK  = 3'd3;
    localparam logic [2:0] ST_EVICT  = 3'd4;
    localparam logic [2:0] ST_ALLOC  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]               r_state;
    t_in_item                 r_req;
    logic [FRAME_COUNT-1:0]   r_busy;
    logic [7:0]               r_frame_seg [FRAME_COUNT];
    logic [7:0]               r_frame_own [FRAME_COUNT];
    logic [FCW-1:0]           r_free;
    logic [SEGMENT_SLOTS-1:0] r_slot_valid;
    logic [SEGMENT_SLOTS-1:0] r_slot_used;
    logic [7:0]               r_slot_seg [SEGMENT_SLOTS];
    logic [SW-1:0]            r_hand;
    logic [SCW-1:0]           r_sc;
    logic [FCW-1:0]           r_fc;
    logic [FCW-1:0]           r_taken;
    logic [GW-1:0]            r_guard;
    logic [SW-1:0]            r_rel_slot;
    logic [7:0]               r_rel_seg;
    logic [1:0]               r_fin_kind;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic          can_emit;
    logic [SW-1:0] sidx;
    logic [FW-1:0] fidx;
    logic [SW-1:0] hand_next;
    logic [SW-1:0] free_slot;

    assign can_emit    = !r_out_valid || i_out_ready;
    assign sidx        = r_sc[SW-1:0];
    assign fidx        = r_fc[FW-1:0];
    assign hand_next   = (r_hand == SW'(SEGMENT_SLOTS - 1)) ? '0 : r_hand + 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // lowest invalid slot
    always_comb begin
        free_slot = '0;
        for (int s = SEGMENT_SLOTS - 1; s >= 0; s--) begin
            if (!r_slot_valid[s]) begin
                free_slot = SW'(s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_busy       <= '0;
            r_free       <= FCW'(FRAME_COUNT);
            r_slot_valid <= '0;
            r_slot_used  <= '0;
            r_hand       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_item;
                        r_sc    <= '0;
                        r_state <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    if (r_req.opcode != OP_LOAD && r_req.opcode != OP_REF &&
                        r_req.opcode != OP_UNLOAD) begin
                        r_fin_kind <= KIND_ERROR;
                        r_state    <= ST_FINISH;
                    end else if (r_req.opcode == OP_LOAD &&
                                 r_req.page_count > 5'(FRAME_COUNT)) begin
                        r_fin_kind <= KIND_ERROR;
                        r_state    <= ST_FINISH;
                    end else if (r_sc == SCW'(SEGMENT_SLOTS)) begin
                        if (r_req.opcode == OP_LOAD) begin
                            r_state <= ST_CHECK;
                        end else begin
                            r_fin_kind <= KIND_ERROR;
                            r_state    <= ST_FINISH;
                        end
                    end else if (r_slot_valid[sidx] &&
                                 r_slot_seg[sidx] == r_req.seg_id) begin
                        if (r_req.opcode == OP_LOAD) begin
                            r_fin_kind <= KIND_ERROR;
                            r_state    <= ST_FINISH;
                        end else if (r_req.opcode == OP_REF) begin
                            r_slot_used[sidx] <= 1'b1;
                            r_fin_kind        <= KIND_DONE;
                            r_state           <= ST_FINISH;
                        end else begin
                            r_rel_slot <= sidx;
                            r_rel_seg  <= r_req.seg_id;
                            r_fc       <= '0;
                            r_state    <= ST_FREL;
                        end
                    end else begin
                        r_sc <= r_sc + 1'b1;
                    end
                end
                ST_FREL: begin
                    if (r_fc == FCW'(FRAME_COUNT)) begin
                        r_slot_valid[r_rel_slot] <= 1'b0;
                        r_slot_used[r_rel_slot]  <= 1'b0;
                        if (r_req.opcode == OP_UNLOAD) begin
                            r_fin_kind <= KIND_DONE;
                            r_state    <= ST_FINISH;
                        end else begin
                            r_state <= ST_CHECK;
                        end
                    end else begin
                        if (r_busy[fidx] && r_frame_seg[fidx] == r_rel_seg) begin
                            r_busy[fidx] <= 1'b0;
                            r_free       <= r_free + 1'b1;
                        end
                        r_fc <= r_fc + 1'b1;
                    end
                end
                ST_CHECK: begin
                    if (5'(r_free) < r_req.page_count || &r_slot_valid) begin
                        r_guard <= '0;
                        r_state <= ST_EVICT;
                    end else begin
                        r_fc    <= '0;
                        r_taken <= '0;
                        r_state <= ST_ALLOC;
                    end
                end
                ST_EVICT: begin
                    if (r_guard == GW'(2 * SEGMENT_SLOTS + 1)) begin
                        r_fin_kind <= KIND_ERROR;
                        r_state    <= ST_FINISH;
                    end else if (r_slot_valid[r_hand] && !r_slot_used[r_hand]) begin
                        if (can_emit) begin
                            r_out_valid         <= 1'b1;
                            r_out.event_kind    <= KIND_EVICT;
                            r_out.frame_index   <= '0;
                            r_out.event_segment <= r_slot_seg[r_hand];
                            r_out.last_of_run   <= 1'b0;
                            r_rel_slot          <= r_hand;
                            r_rel_seg           <= r_slot_seg[r_hand];
                            r_hand              <= hand_next;
                            r_fc                <= '0;
                            r_state             <= ST_FREL;
                        end
                    end else begin
                        // second chance: clear the mark and move on
                        r_slot_used[r_hand] <= 1'b0;
                        r_hand              <= hand_next;
                        r_guard             <= r_guard + 1'b1;
                    end
                end
                ST_ALLOC: begin
                    if (r_fc == FCW'(FRAME_COUNT) || 5'(r_taken) == r_req.page_count) begin
                        r_slot_valid[free_slot] <= 1'b1;
                        r_slot_used[free_slot]  <= 1'b0;
                        r_slot_seg[free_slot]   <= r_req.seg_id;
                        r_fin_kind              <= KIND_DONE;
                        r_state                 <= ST_FINISH;
                    end else if (r_busy[fidx]) begin
                        r_fc <= r_fc + 1'b1;
                    end else if (can_emit) begin
                        r_busy[fidx]        <= 1'b1;
                        r_frame_seg[fidx]   <= r_req.seg_id;
                        r_frame_own[fidx]   <= r_req.owner_process;
                        r_free              <= r_free - 1'b1;
                        r_taken             <= r_taken + 1'b1;
                        r_fc                <= r_fc + 1'b1;
                        r_out_valid         <= 1'b1;
                        r_out.event_kind    <= KIND_FRAME;
                        r_out.frame_index   <= 4'(fidx);
                        r_out.event_segment <= r_req.seg_id;
                        r_out.last_of_run   <= 1'b0;
                    end
                end
                ST_FINISH: begin
                    if (can_emit) begin
                        r_out_valid         <= 1'b1;
                        r_out.event_kind    <= r_fin_kind;
                        r_out.frame_index   <= '0;
                        r_out.event_segment <= r_req.seg_id;
                        r_out.last_of_run   <= 1'b1;
                        r_state             <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free == FCW'(FRAME_COUNT - $countones(r_busy)))
        else $error("free count out of step with busy frames");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand < SW'(SEGMENT_SLOTS - 1) || r_hand == SW'(SEGMENT_SLOTS - 1))
        else $error("clock hand past last slot");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("accepted a second item without working the first");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule
